### src/epcf_pkg.sv
// ----------------------------------------------------------------------------
// epcf_pkg
// Shared types and constants of the ellipsoid point cloud filter.
// ----------------------------------------------------------------------------
package epcf_pkg;

	localparam int unsigned MAX_POINTS_DEF = 65536;

	localparam int unsigned COORD_W = 21;
	localparam int unsigned REG_W   = 63;
	localparam int unsigned DIST_W  = 32;
	localparam int unsigned RANK_W  = 16;
	localparam int unsigned ICNT_W  = 17;

	// Register indexes on the configuration port.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_ROW0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_ROW1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_ROW2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd3;

	// Reset values: identity matrix in Q5.16, center at the origin.
	localparam logic [REG_W-1:0] INV_ROW0_RST = 63'd65536;
	localparam logic [REG_W-1:0] INV_ROW1_RST = 63'd65536 << 21;
	localparam logic [REG_W-1:0] INV_ROW2_RST = 63'd65536 << 42;
	localparam logic [REG_W-1:0] CENTER_RST   = '0;

	localparam logic [DIST_W-1:0] ONE_Q16    = 32'h0001_0000;
	localparam logic [ICNT_W-1:0] ICNT_MAX   = 17'h1_0000;
	localparam logic [RANK_W-1:0] RANK_MAX   = 16'hFFFF;

	// Queue between the arithmetic front and the bookkeeping back.
	localparam int unsigned QDEPTH  = 8;
	localparam int unsigned QPTR_W  = 3;
	localparam int unsigned QCNT_W  = 4;
	localparam int unsigned PIPE_CNT_W = 3;

	typedef struct packed {
		logic                     last;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [DIST_W-1:0]        dsq;
	} word_t;

endpackage

### src/epcf_front.sv
// ----------------------------------------------------------------------------
// epcf_front
// Configuration registers and the four-stage distance pipeline.
// ----------------------------------------------------------------------------
module epcf_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [epcf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [epcf_pkg::REG_W-1:0]        cfg_data,
	input  logic                              in_fire,
	input  logic signed [epcf_pkg::COORD_W-1:0] px,
	input  logic signed [epcf_pkg::COORD_W-1:0] py,
	input  logic signed [epcf_pkg::COORD_W-1:0] pz,
	input  logic                              cloud_end,
	output logic [epcf_pkg::PIPE_CNT_W-1:0]   pipe_cnt,
	output logic                              push,
	output epcf_pkg::word_t                   push_word
);

	logic [epcf_pkg::REG_W-1:0] inv_q [3];
	logic [epcf_pkg::REG_W-1:0] center_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [epcf_pkg::COORD_W-1:0] pt_s1 [3];
	logic signed [epcf_pkg::COORD_W-1:0] pt_s2 [3];
	logic signed [epcf_pkg::COORD_W-1:0] pt_s3 [3];
	logic signed [epcf_pkg::COORD_W-1:0] pt_s4 [3];
	logic signed [21:0] diff_s1 [3];
	logic signed [42:0] prod_s2 [3][3];
	logic [23:0] mag_s3 [3];
	logic sat_s3, sat_s4;
	logic [47:0] sq_s4 [3];

	logic signed [epcf_pkg::COORD_W-1:0] pin [3];
	logic signed [44:0] row_sum [3];
	logic [44:0] row_mag [3];
	logic [34:0] row_sh [3];
	logic row_ovf;
	logic [49:0] acc;
	logic [33:0] acc_sh;

	assign pin[0] = px;
	assign pin[1] = py;
	assign pin[2] = pz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q[0] <= epcf_pkg::INV_ROW0_RST;
			inv_q[1] <= epcf_pkg::INV_ROW1_RST;
			inv_q[2] <= epcf_pkg::INV_ROW2_RST;
			center_q <= epcf_pkg::CENTER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				epcf_pkg::REG_INV_ROW0: inv_q[0] <= cfg_data;
				epcf_pkg::REG_INV_ROW1: inv_q[1] <= cfg_data;
				epcf_pkg::REG_INV_ROW2: inv_q[2] <= cfg_data;
				epcf_pkg::REG_CENTER:   center_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Row sums, magnitudes truncated toward zero, and the overflow check.
	always_comb begin
		row_ovf = 1'b0;
		for (int r = 0; r < 3; r++) begin
			row_sum[r] = 45'(prod_s2[r][0]) + 45'(prod_s2[r][1]) + 45'(prod_s2[r][2]);
			row_mag[r] = row_sum[r][44] ? 45'(-row_sum[r]) : 45'(row_sum[r]);
			row_sh[r]  = row_mag[r][44:10];
			if (row_sh[r][34:24] != '0) begin
				row_ovf = 1'b1;
			end
		end
	end

	// The pipeline never stalls; the top only admits a point when the
	// queue has room for everything in flight.
	always_ff @(posedge clk) begin
		last_s1 <= cloud_end;
		for (int k = 0; k < 3; k++) begin
			pt_s1[k]   <= pin[k];
			diff_s1[k] <= 22'(pin[k]) -
				22'($signed(center_q[k*epcf_pkg::COORD_W +: epcf_pkg::COORD_W]));
		end

		last_s2 <= last_s1;
		for (int r = 0; r < 3; r++) begin
			pt_s2[r] <= pt_s1[r];
			for (int k = 0; k < 3; k++) begin
				prod_s2[r][k] <= 43'(diff_s1[k]) *
					43'($signed(inv_q[r][k*epcf_pkg::COORD_W +: epcf_pkg::COORD_W]));
			end
		end

		last_s3 <= last_s2;
		sat_s3  <= row_ovf;
		for (int r = 0; r < 3; r++) begin
			pt_s3[r]  <= pt_s2[r];
			mag_s3[r] <= row_sh[r][23:0];
		end

		last_s4 <= last_s3;
		sat_s4  <= sat_s3;
		for (int r = 0; r < 3; r++) begin
			pt_s4[r] <= pt_s3[r];
			sq_s4[r] <= 48'(mag_s3[r]) * 48'(mag_s3[r]);
		end
	end

	always_comb begin
		acc    = 50'(sq_s4[0]) + 50'(sq_s4[1]) + 50'(sq_s4[2]);
		acc_sh = acc[49:16];
		push_word.last = last_s4;
		push_word.x    = pt_s4[0];
		push_word.y    = pt_s4[1];
		push_word.z    = pt_s4[2];
		if (sat_s4 || acc_sh[33:32] != 2'b00) begin
			push_word.dsq = '1;
		end else begin
			push_word.dsq = acc_sh[31:0];
		end
	end

	assign push     = v_s4;
	assign pipe_cnt = epcf_pkg::PIPE_CNT_W'(v_s1) + epcf_pkg::PIPE_CNT_W'(v_s2) +
		epcf_pkg::PIPE_CNT_W'(v_s3) + epcf_pkg::PIPE_CNT_W'(v_s4);

endmodule

### src/epcf_queue.sv
// ----------------------------------------------------------------------------
// epcf_queue
// Small first-in first-out queue of distance words between front and back.
// ----------------------------------------------------------------------------
module epcf_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  epcf_pkg::word_t               push_word,
	input  logic                          pop,
	output epcf_pkg::word_t               head,
	output logic                          not_empty,
	output logic [epcf_pkg::QCNT_W-1:0]   count
);

	epcf_pkg::word_t mem_q [epcf_pkg::QDEPTH];
	logic [epcf_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [epcf_pkg::QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == epcf_pkg::QCNT_W'(epcf_pkg::QDEPTH)))
		else $error("word pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && cnt_q == '0))
		else $error("word popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= epcf_pkg::QCNT_W'(epcf_pkg::QDEPTH))
		else $error("queue count beyond its depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == epcf_pkg::QCNT_W'(epcf_pkg::QDEPTH)) |->
		wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with the count");
`endif

endmodule

### src/epcf_back.sv
// ----------------------------------------------------------------------------
// epcf_back
// Running cloud statistics and the registered result word.
// ----------------------------------------------------------------------------
module epcf_back #(
	parameter int unsigned MAX_POINTS = epcf_pkg::MAX_POINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  epcf_pkg::word_t                      head,
	input  logic                                 not_empty,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 is_inside,
	output logic [epcf_pkg::DIST_W-1:0]          dist_sq,
	output logic [epcf_pkg::RANK_W-1:0]          inside_rank,
	output logic signed [epcf_pkg::COORD_W-1:0]  out_x,
	output logic signed [epcf_pkg::COORD_W-1:0]  out_y,
	output logic signed [epcf_pkg::COORD_W-1:0]  out_z,
	output logic [epcf_pkg::RANK_W-1:0]          nearest_index,
	output logic [epcf_pkg::DIST_W-1:0]          nearest_dist_sq,
	output logic [epcf_pkg::ICNT_W-1:0]          inside_count,
	output logic [epcf_pkg::RANK_W-1:0]          nearest_inside_rank,
	output logic                                 result_last
);

	localparam int unsigned CNT_W = $clog2(MAX_POINTS);
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_POINTS - 1);

	logic [CNT_W-1:0] point_cnt_q, best_idx_q;
	logic [epcf_pkg::DIST_W-1:0] best_dist_q, best_in_dist_q;
	logic [epcf_pkg::ICNT_W-1:0] in_cnt_q;
	logic [epcf_pkg::RANK_W-1:0] best_in_rank_q;
	logic out_valid_q;

	logic pt_in;
	logic [epcf_pkg::RANK_W-1:0] rank;
	logic [CNT_W-1:0] nx_point_cnt, nx_best_idx;
	logic [epcf_pkg::DIST_W-1:0] nx_best_dist, nx_best_in_dist;
	logic [epcf_pkg::ICNT_W-1:0] nx_in_cnt;
	logic [epcf_pkg::RANK_W-1:0] nx_best_in_rank;
	logic [31:0] idx_ext;

	assign pop = not_empty && (!out_valid_q || out_ready);

	always_comb begin
		pt_in = (head.dsq <= epcf_pkg::ONE_Q16);
		rank  = (in_cnt_q > epcf_pkg::ICNT_W'(epcf_pkg::RANK_MAX)) ?
			epcf_pkg::RANK_MAX : in_cnt_q[epcf_pkg::RANK_W-1:0];

		nx_best_dist = best_dist_q;
		nx_best_idx  = best_idx_q;
		if (head.dsq < best_dist_q) begin
			nx_best_dist = head.dsq;
			nx_best_idx  = point_cnt_q;
		end
		nx_point_cnt = (point_cnt_q < LAST_IDX) ? point_cnt_q + 1'b1 : point_cnt_q;

		nx_best_in_dist = best_in_dist_q;
		nx_best_in_rank = best_in_rank_q;
		nx_in_cnt       = in_cnt_q;
		if (pt_in) begin
			// Ties go to the later inside point.
			if (head.dsq <= best_in_dist_q) begin
				nx_best_in_dist = head.dsq;
				nx_best_in_rank = rank;
			end
			if (in_cnt_q != epcf_pkg::ICNT_MAX) begin
				nx_in_cnt = in_cnt_q + 1'b1;
			end
		end
		idx_ext = 32'(nx_best_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			point_cnt_q    <= '0;
			best_idx_q     <= '0;
			best_dist_q    <= '1;
			in_cnt_q       <= '0;
			best_in_dist_q <= '1;
			best_in_rank_q <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (head.last) begin
					point_cnt_q    <= '0;
					best_idx_q     <= '0;
					best_dist_q    <= '1;
					in_cnt_q       <= '0;
					best_in_dist_q <= '1;
					best_in_rank_q <= '0;
				end else begin
					point_cnt_q    <= nx_point_cnt;
					best_idx_q     <= nx_best_idx;
					best_dist_q    <= nx_best_dist;
					in_cnt_q       <= nx_in_cnt;
					best_in_dist_q <= nx_best_in_dist;
					best_in_rank_q <= nx_best_in_rank;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			is_inside   <= pt_in;
			dist_sq     <= head.dsq;
			inside_rank <= pt_in ? rank : '0;
			out_x       <= head.x;
			out_y       <= head.y;
			out_z       <= head.z;
			result_last <= head.last;
			if (head.last) begin
				nearest_index <= (idx_ext > 32'(epcf_pkg::RANK_MAX)) ?
					epcf_pkg::RANK_MAX : idx_ext[epcf_pkg::RANK_W-1:0];
				nearest_dist_sq     <= nx_best_dist;
				inside_count        <= nx_in_cnt;
				nearest_inside_rank <= nx_best_in_rank;
			end else begin
				nearest_index       <= '0;
				nearest_dist_sq     <= '0;
				inside_count        <= '0;
				nearest_inside_rank <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(dist_sq))
		else $error("pending result changed before it was taken");
	a_cleared_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.last |=> point_cnt_q == '0 && in_cnt_q == '0 && best_dist_q == '1)
		else $error("running state not cleared after the last point");
	a_rank_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_cnt_q == '0 |-> best_in_rank_q == '0)
		else $error("inside rank held without any inside point");
`endif

endmodule

### src/ellipsoid_point_cloud_filter_core.sv
// ----------------------------------------------------------------------------
// ellipsoid_point_cloud_filter_core
// Ellipsoid membership test and nearest point search over a point stream.
//
//   Channel  Handshake              Word
//   cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//   in       in_valid/in_ready      px, py, pz, cloud_end
//   out      out_valid/out_ready    is_inside ... result_last
//
// One point per cycle while out_ready is held high; a point's result is registered
// after the four pipeline stages, the queue and the output register.
// The eight-word queue sets the credit: in_ready drops once the pipeline and
// the queue together hold eight points, so output stalls back up into it.
// Reset restores the identity matrix, a zero center and cleared statistics.
// ----------------------------------------------------------------------------
module ellipsoid_point_cloud_filter_core #(
	parameter int unsigned MAX_POINTS = epcf_pkg::MAX_POINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [epcf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [epcf_pkg::REG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [epcf_pkg::COORD_W-1:0]  px,
	input  logic signed [epcf_pkg::COORD_W-1:0]  py,
	input  logic signed [epcf_pkg::COORD_W-1:0]  pz,
	input  logic                                 cloud_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 is_inside,
	output logic [epcf_pkg::DIST_W-1:0]          dist_sq,
	output logic [epcf_pkg::RANK_W-1:0]          inside_rank,
	output logic signed [epcf_pkg::COORD_W-1:0]  out_x,
	output logic signed [epcf_pkg::COORD_W-1:0]  out_y,
	output logic signed [epcf_pkg::COORD_W-1:0]  out_z,
	output logic [epcf_pkg::RANK_W-1:0]          nearest_index,
	output logic [epcf_pkg::DIST_W-1:0]          nearest_dist_sq,
	output logic [epcf_pkg::ICNT_W-1:0]          inside_count,
	output logic [epcf_pkg::RANK_W-1:0]          nearest_inside_rank,
	output logic                                 result_last
);

	logic [epcf_pkg::PIPE_CNT_W-1:0] pipe_cnt;
	logic [epcf_pkg::QCNT_W-1:0] q_cnt;
	logic [epcf_pkg::QCNT_W:0] in_flight;
	logic push, pop, not_empty, in_fire;
	epcf_pkg::word_t push_word, head;

	assign cfg_ready = 1'b1;
	assign in_flight = (epcf_pkg::QCNT_W + 1)'(pipe_cnt) + (epcf_pkg::QCNT_W + 1)'(q_cnt);
	assign in_ready  = (in_flight < (epcf_pkg::QCNT_W + 1)'(epcf_pkg::QDEPTH));
	assign in_fire   = in_valid && in_ready;

	epcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.px        (px),
		.py        (py),
		.pz        (pz),
		.cloud_end (cloud_end),
		.pipe_cnt  (pipe_cnt),
		.push      (push),
		.push_word (push_word)
	);

	epcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.count     (q_cnt)
	);

	epcf_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.head                (head),
		.not_empty           (not_empty),
		.pop                 (pop),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.is_inside           (is_inside),
		.dist_sq             (dist_sq),
		.inside_rank         (inside_rank),
		.out_x               (out_x),
		.out_y               (out_y),
		.out_z               (out_z),
		.nearest_index       (nearest_index),
		.nearest_dist_sq     (nearest_dist_sq),
		.inside_count        (inside_count),
		.nearest_inside_rank (nearest_inside_rank),
		.result_last         (result_last)
	);

endmodule

### dv/tb_ellipsoid_point_cloud_filter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ellipsoid_point_cloud_filter_core
// Self-checking bench for the ellipsoid point cloud filter. A behavioral
// copy of the filter arithmetic and the running cloud statistics predicts
// every result word, and each word on the output channel is checked in order.
// The stimulus covers directed geometry, register extremes, ignored indexes,
// randomized clouds under random idling, backpressure, and one dense cloud
// with every point inside.
// ----------------------------------------------------------------------------
module tb_ellipsoid_point_cloud_filter_core;

	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_CLOUD   = 48;

	typedef struct {
		logic                              in_flag;
		logic [epcf_pkg::DIST_W-1:0]       dval;
		logic [epcf_pkg::RANK_W-1:0]       rank;
		logic [epcf_pkg::COORD_W-1:0]      x;
		logic [epcf_pkg::COORD_W-1:0]      y;
		logic [epcf_pkg::COORD_W-1:0]      z;
		logic [epcf_pkg::RANK_W-1:0]       near_idx;
		logic [epcf_pkg::DIST_W-1:0]       near_dist;
		logic [epcf_pkg::ICNT_W-1:0]       in_count;
		logic [epcf_pkg::RANK_W-1:0]       near_in_rank;
		logic                              last;
	} point_verdict_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  cfg_valid;
	logic                                  cfg_ready;
	logic [epcf_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [epcf_pkg::REG_W-1:0]            cfg_data;
	logic                                  in_valid;
	logic                                  in_ready;
	logic signed [epcf_pkg::COORD_W-1:0]   px;
	logic signed [epcf_pkg::COORD_W-1:0]   py;
	logic signed [epcf_pkg::COORD_W-1:0]   pz;
	logic                                  cloud_end;
	logic                                  out_valid;
	logic                                  out_ready;
	logic                                  is_inside;
	logic [epcf_pkg::DIST_W-1:0]           dist_sq;
	logic [epcf_pkg::RANK_W-1:0]           inside_rank;
	logic signed [epcf_pkg::COORD_W-1:0]   out_x;
	logic signed [epcf_pkg::COORD_W-1:0]   out_y;
	logic signed [epcf_pkg::COORD_W-1:0]   out_z;
	logic [epcf_pkg::RANK_W-1:0]           nearest_index;
	logic [epcf_pkg::DIST_W-1:0]           nearest_dist_sq;
	logic [epcf_pkg::ICNT_W-1:0]           inside_count;
	logic [epcf_pkg::RANK_W-1:0]           nearest_inside_rank;
	logic                                  result_last;

	// Shadow copy of the configuration and of the running cloud statistics.
	logic [epcf_pkg::REG_W-1:0]  inv_reg [3];
	logic [epcf_pkg::REG_W-1:0]  ctr_reg;
	int unsigned                 pt_idx;
	int unsigned                 in_cnt;
	int unsigned                 best_idx;
	int unsigned                 best_in_rank;
	logic [epcf_pkg::DIST_W-1:0] best_d;
	logic [epcf_pkg::DIST_W-1:0] best_in_d;

	point_verdict_t pending_verdicts [$];

	int  mismatches = 0;
	int  n_points   = 0;
	int  n_checked  = 0;
	int  n_clouds   = 0;
	int  n_cfg      = 0;
	bit  tx_idle    = 1'b1;
	bit  rx_idle    = 1'b1;
	int  stall_hold = 0;

	ellipsoid_point_cloud_filter_core DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.px                  (px),
		.py                  (py),
		.pz                  (pz),
		.cloud_end           (cloud_end),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.is_inside           (is_inside),
		.dist_sq             (dist_sq),
		.inside_rank         (inside_rank),
		.out_x               (out_x),
		.out_y               (out_y),
		.out_z               (out_z),
		.nearest_index       (nearest_index),
		.nearest_dist_sq     (nearest_dist_sq),
		.inside_count        (inside_count),
		.nearest_inside_rank (nearest_inside_rank),
		.result_last         (result_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------
	function automatic longint coord_of(logic [epcf_pkg::REG_W-1:0] r, int k);
		logic signed [epcf_pkg::COORD_W-1:0] f;
		f = r[epcf_pkg::COORD_W*k +: epcf_pkg::COORD_W];
		return f;
	endfunction

	function automatic logic [epcf_pkg::REG_W-1:0] pack3(int a, int b, int c);
		logic [epcf_pkg::COORD_W-1:0] fa, fb, fc;
		fa = a[epcf_pkg::COORD_W-1:0];
		fb = b[epcf_pkg::COORD_W-1:0];
		fc = c[epcf_pkg::COORD_W-1:0];
		return {fc, fb, fa};
	endfunction

	function automatic logic [epcf_pkg::DIST_W-1:0] ellipsoid_norm_sq(
			logic signed [epcf_pkg::COORD_W-1:0] x,
			logic signed [epcf_pkg::COORD_W-1:0] y,
			logic signed [epcf_pkg::COORD_W-1:0] z);
		longint diff [3];
		longint row_sum, mag, acc;
		bit     sat;
		diff[0] = longint'(x) - coord_of(ctr_reg, 0);
		diff[1] = longint'(y) - coord_of(ctr_reg, 1);
		diff[2] = longint'(z) - coord_of(ctr_reg, 2);
		acc = 0;
		sat = 1'b0;
		for (int r = 0; r < 3; r++) begin
			row_sum = 0;
			for (int k = 0; k < 3; k++)
				row_sum += diff[k] * coord_of(inv_reg[r], k);
			// Magnitude is truncated toward zero from Q.26 down to Q.16.
			mag = (row_sum < 0) ? -row_sum : row_sum;
			mag = mag >>> 10;
			if (mag >= (64'sd1 <<< 24))
				sat = 1'b1;
			else
				acc += mag * mag;
		end
		if (sat)
			return '1;
		acc = acc >>> 16;
		return (acc > 64'sh0000_0000_FFFF_FFFF) ? '1 : acc[31:0];
	endfunction

	function automatic void clear_stats();
		pt_idx       = 0;
		in_cnt       = 0;
		best_idx     = 0;
		best_in_rank = 0;
		best_d       = '1;
		best_in_d    = '1;
	endfunction

	task automatic classify_point(logic [epcf_pkg::COORD_W-1:0] x,
			logic [epcf_pkg::COORD_W-1:0] y, logic [epcf_pkg::COORD_W-1:0] z,
			logic last);
		point_verdict_t v;
		logic [epcf_pkg::DIST_W-1:0] d;
		d = ellipsoid_norm_sq(x, y, z);
		v = '{default: '0};
		v.in_flag = (d <= epcf_pkg::ONE_Q16);
		v.dval    = d;
		v.x       = x;
		v.y       = y;
		v.z       = z;
		// Overall minimum keeps the first point that reaches it.
		if (d < best_d) begin
			best_d   = d;
			best_idx = pt_idx;
		end
		if (pt_idx < epcf_pkg::MAX_POINTS_DEF - 1)
			pt_idx++;
		// Inside minimum follows the last point that ties it.
		if (v.in_flag) begin
			v.rank = (in_cnt > epcf_pkg::RANK_MAX) ? epcf_pkg::RANK_MAX :
				in_cnt[epcf_pkg::RANK_W-1:0];
			if (d <= best_in_d) begin
				best_in_d    = d;
				best_in_rank = v.rank;
			end
			if (in_cnt < epcf_pkg::ICNT_MAX)
				in_cnt++;
		end
		if (last) begin
			v.last         = 1'b1;
			v.near_idx     = (best_idx > epcf_pkg::RANK_MAX) ? epcf_pkg::RANK_MAX :
				best_idx[epcf_pkg::RANK_W-1:0];
			v.near_dist    = best_d;
			v.in_count     = in_cnt[epcf_pkg::ICNT_W-1:0];
			v.near_in_rank = best_in_rank[epcf_pkg::RANK_W-1:0];
			clear_stats();
			n_clouds++;
		end
		pending_verdicts = {pending_verdicts, v};
		n_points++;
	endtask

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	task automatic send_point(int x, int y, int z, logic last);
		int gap;
		logic [epcf_pkg::COORD_W-1:0] xs, ys, zs;
		xs  = x[epcf_pkg::COORD_W-1:0];
		ys  = y[epcf_pkg::COORD_W-1:0];
		zs  = z[epcf_pkg::COORD_W-1:0];
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		px        <= xs;
		py        <= ys;
		pz        <= zs;
		cloud_end <= last;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		classify_point(xs, ys, zs, last);
	endtask

	task automatic write_reg(logic [epcf_pkg::CFG_IDX_W-1:0] idx,
			logic [epcf_pkg::REG_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
		case (idx)
			epcf_pkg::REG_INV_ROW0: inv_reg[0] = val;
			epcf_pkg::REG_INV_ROW1: inv_reg[1] = val;
			epcf_pkg::REG_INV_ROW2: inv_reg[2] = val;
			epcf_pkg::REG_CENTER:   ctr_reg    = val;
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [epcf_pkg::REG_W-1:0] full_word();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[epcf_pkg::REG_W-1:0];
	endfunction

	function automatic int q516_entry();
		return int'($urandom_range(0, 262144)) - 131072;
	endfunction

	function automatic int near_coord(int c, int spread);
		if ($urandom_range(0, 4) == 0)
			return int'($urandom);
		return c + int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	task automatic send_near(int spread, logic last);
		send_point(near_coord(int'(coord_of(ctr_reg, 0)), spread),
			near_coord(int'(coord_of(ctr_reg, 1)), spread),
			near_coord(int'(coord_of(ctr_reg, 2)), spread), last);
	endtask

	// ------------------------------------------------------------------------
	// Result sink and checker
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int wait_cycles;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (stall_hold > 0) begin
				wait_cycles = stall_hold;
				stall_hold  = 0;
			end else begin
				wait_cycles = rx_idle ? $urandom_range(0, 15) : 0;
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : verdict_check
		point_verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			n_checked++;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word with no point outstanding", $realtime);
			end else begin
				want = pending_verdicts.pop_front();
				if (is_inside !== want.in_flag || dist_sq !== want.dval
						|| inside_rank !== want.rank || out_x !== want.x
						|| out_y !== want.y || out_z !== want.z
						|| nearest_index !== want.near_idx
						|| nearest_dist_sq !== want.near_dist
						|| inside_count !== want.in_count
						|| nearest_inside_rank !== want.near_in_rank
						|| result_last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch, expected in=%0d d=%h rk=%0d p=%h/%h/%h",
							$realtime, want.in_flag, want.dval, want.rank,
							want.x, want.y, want.z);
						$display("    last=%0d ni=%0d nd=%h ic=%0d nr=%0d",
							want.last, want.near_idx, want.near_dist,
							want.in_count, want.near_in_rank);
						$display("  actual in=%0d d=%h rk=%0d p=%h/%h/%h",
							is_inside, dist_sq, inside_rank, out_x, out_y, out_z);
						$display("    last=%0d ni=%0d nd=%h ic=%0d nr=%0d",
							result_last, nearest_index, nearest_dist_sq,
							inside_count, nearest_inside_rank);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed_geometry();
		// Identity matrix and zero center from reset: 1024 is exactly 1.0.
		send_point(1024, 0, 0, 1'b0);
		send_point(1025, 0, 0, 1'b0);
		send_point(0, -1024, 0, 1'b0);
		// Three equal distances: first wins overall, last wins among inside.
		send_point(100, 0, 0, 1'b0);
		send_point(0, 100, 0, 1'b0);
		send_point(0, 0, -100, 1'b0);
		send_point(-1048576, -1048576, -1048576, 1'b0);
		send_point(1048575, 1048575, 1048575, 1'b0);
		// Each component just fits, but the sum of squares overflows 32 bits.
		send_point(262143, 262143, 262143, 1'b0);
		send_point(262144, 0, 0, 1'b0);
		send_point(-1, 1, -1, 1'b1);
		// Single-point cloud, then a cloud with nothing inside.
		send_point(0, 0, 0, 1'b1);
		send_point(5000, 0, 0, 1'b0);
		send_point(0, -5000, 0, 1'b1);
	endtask

	task automatic test_register_extremes();
		wait_drained();
		write_reg(epcf_pkg::REG_INV_ROW0, pack3(1048575, 1048575, 1048575));
		write_reg(epcf_pkg::REG_INV_ROW1, pack3(1048575, 1048575, 1048575));
		write_reg(epcf_pkg::REG_INV_ROW2, pack3(1048575, 1048575, 1048575));
		write_reg(epcf_pkg::REG_CENTER, pack3(1048575, 1048575, 1048575));
		send_point(-1048576, -1048576, -1048576, 1'b0);
		send_point(1048575, 1048575, 1048575, 1'b0);
		send_point(1048574, 1048575, 1048575, 1'b1);
		wait_drained();
		write_reg(epcf_pkg::REG_INV_ROW0, pack3(-1048576, -1048576, -1048576));
		write_reg(epcf_pkg::REG_INV_ROW1, pack3(-1048576, -1048576, -1048576));
		write_reg(epcf_pkg::REG_INV_ROW2, pack3(-1048576, -1048576, -1048576));
		write_reg(epcf_pkg::REG_CENTER, pack3(-1048576, -1048576, -1048576));
		send_point(1048575, 1048575, 1048575, 1'b0);
		send_point(-1048576, -1048576, -1048576, 1'b0);
		send_point(-1048575, -1048576, -1048576, 1'b1);
		wait_drained();
		// A zero matrix puts every point at distance zero.
		write_reg(epcf_pkg::REG_INV_ROW0, '0);
		write_reg(epcf_pkg::REG_INV_ROW1, '0);
		write_reg(epcf_pkg::REG_INV_ROW2, '0);
		write_reg(epcf_pkg::REG_CENTER, full_word());
		send_point(1048575, -1048576, 0, 1'b0);
		send_point(-1048576, 1048575, 12345, 1'b1);
	endtask

	task automatic test_ignored_index();
		int k;
		wait_drained();
		write_reg(epcf_pkg::REG_INV_ROW0, epcf_pkg::INV_ROW0_RST);
		write_reg(epcf_pkg::REG_INV_ROW1, epcf_pkg::INV_ROW1_RST);
		write_reg(epcf_pkg::REG_INV_ROW2, epcf_pkg::INV_ROW2_RST);
		write_reg(epcf_pkg::REG_CENTER, pack3(2048, -2048, 512));
		for (k = 1; k <= 4; k++)
			write_reg(epcf_pkg::CFG_IDX_W'(epcf_pkg::REG_CENTER + k), full_word());
		send_point(2048, -2048, 512, 1'b0);
		send_point(2500, -2048, 512, 1'b1);
	endtask

	task automatic test_random_clouds();
		int ph, i, k, cloud_left, spread, scale;
		cloud_left = 0;
		spread     = 256;
		for (ph = 0; ph < 10; ph++) begin
			wait_drained();
			for (k = 0; k < 3; k++) begin
				case (ph % 4)
					1: write_reg(epcf_pkg::CFG_IDX_W'(epcf_pkg::REG_INV_ROW0 + k),
						full_word());
					3: begin
						scale = $urandom_range(16384, 131072);
						write_reg(epcf_pkg::CFG_IDX_W'(epcf_pkg::REG_INV_ROW0 + k),
							pack3(k == 0 ? scale : 0, k == 1 ? scale : 0,
							k == 2 ? scale : 0));
					end
					default: write_reg(epcf_pkg::CFG_IDX_W'(epcf_pkg::REG_INV_ROW0 + k),
						pack3(q516_entry(), q516_entry(), q516_entry()));
				endcase
			end
			if (ph % 4 == 1 || ph % 4 == 2)
				write_reg(epcf_pkg::REG_CENTER, full_word());
			else
				write_reg(epcf_pkg::REG_CENTER,
					pack3(int'($urandom_range(0, 8192)) - 4096,
					int'($urandom_range(0, 8192)) - 4096,
					int'($urandom_range(0, 8192)) - 4096));
			if ($urandom_range(0, 2) == 0)
				write_reg(epcf_pkg::CFG_IDX_W'(epcf_pkg::REG_CENTER + $urandom_range(1, 4)),
					full_word());
			// Some phases run with no idling at all on one or both sides.
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			for (i = 0; i < 70; i++) begin
				if (cloud_left == 0) begin
					cloud_left = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
					case ($urandom_range(0, 3))
						0: spread = 32;
						1: spread = 256;
						2: spread = 1024;
						default: spread = 4096;
					endcase
				end
				send_near(spread, cloud_left == 1);
				cloud_left--;
			end
		end
		while (cloud_left > 0) begin
			send_near(spread, cloud_left == 1);
			cloud_left--;
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_backpressure();
		int i;
		wait_drained();
		tx_idle    = 1'b0;
		rx_idle    = 1'b0;
		// The sink takes one word and then holds off while points keep coming.
		stall_hold = 300;
		for (i = 0; i < 40; i++)
			send_near(1024, 1'b0);
		// Pause the points mid-cloud until every result has come back.
		wait_drained();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (i = 0; i < 20; i++)
			send_near(1024, i == 19);
	endtask

	task automatic test_long_cloud();
		int i, k;
		int c [3];
		wait_drained();
		write_reg(epcf_pkg::REG_INV_ROW0, epcf_pkg::INV_ROW0_RST);
		write_reg(epcf_pkg::REG_INV_ROW1, epcf_pkg::INV_ROW1_RST);
		write_reg(epcf_pkg::REG_INV_ROW2, epcf_pkg::INV_ROW2_RST);
		write_reg(epcf_pkg::REG_CENTER, epcf_pkg::CENTER_RST);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		// Every point is inside and off center; the last one sits on the
		// center, so both minima land on the final point.
		for (i = 0; i < LONG_CLOUD; i++) begin
			for (k = 0; k < 3; k++) begin
				c[k] = $urandom_range(100, 500);
				if ($urandom_range(0, 1) != 0)
					c[k] = -c[k];
			end
			if (i == LONG_CLOUD - 1)
				send_point(0, 0, 0, 1'b1);
			else
				send_point(c[0], c[1], c[2], 1'b0);
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (i = 0; i < 6; i++)
			send_near(512, i == 5);
	endtask

	initial begin : stimulus
		int spin;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = epcf_pkg::REG_INV_ROW0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		px        = '0;
		py        = '0;
		pz        = '0;
		cloud_end = 1'b0;
		inv_reg[0] = epcf_pkg::INV_ROW0_RST;
		inv_reg[1] = epcf_pkg::INV_ROW1_RST;
		inv_reg[2] = epcf_pkg::INV_ROW2_RST;
		ctr_reg    = epcf_pkg::CENTER_RST;
		clear_stats();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_geometry();
		test_register_extremes();
		test_ignored_index();
		test_random_clouds();
		test_backpressure();
		test_long_cloud();

		in_valid <= 1'b0;
		for (spin = 0; spin < 20000 && pending_verdicts.size() != 0; spin++)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		mismatches += pending_verdicts.size();

		$display("Checked %0d result words for %0d points in %0d clouds, %0d register writes.",
			n_checked, n_points, n_clouds, n_cfg);
		$display("Covered boundary and saturated distances, ties, register extremes,");
		$display("ignored indexes, backpressure and a dense all-inside cloud.");
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### ellipsoid_point_cloud_filter_core.f
src/epcf_pkg.sv
src/epcf_front.sv
src/epcf_queue.sv
src/epcf_back.sv
src/ellipsoid_point_cloud_filter_core.sv
dv/tb_ellipsoid_point_cloud_filter_core.sv
